>>> sv/afc_pkg.sv
// Shared types, widths and helpers for the box versus frustum cull unit.
package afc_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned CoefW     = CoordW + 1;
  localparam int unsigned ProdW     = CoefW + CoordW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumCols   = 4;
  localparam int unsigned NumPlanes = 6;
  localparam int unsigned NumCfg    = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned WCol      = 3;
  localparam int unsigned BaseRow   = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;

  typedef coord_t [NumAxes-1:0] coord_vec_t;

  typedef struct packed {
    coef_t [NumAxes-1:0] n;
    coef_t               w;
  } plane_t;

  typedef plane_t [NumPlanes-1:0]               plane_arr_t;
  typedef prod_t  [NumPlanes-1:0][NumAxes-1:0] prod_arr_t;
  typedef logic   [NumCfg-1:0][CfgDataW-1:0]   cfg_arr_t;

  // Sign-extend one Q15.16 matrix entry to coefficient width.
  function automatic coef_t ext_coef(input logic [CoordW-1:0] v);
    return coef_t'({v[CoordW-1], v});
  endfunction

endpackage

>>> sv/afc_ifs.sv
// Handshake channels for box words and cull result words.
interface afc_box_if;
  logic             valid;
  logic             ready;
  afc_pkg::coord_t  min_x;
  afc_pkg::coord_t  min_y;
  afc_pkg::coord_t  min_z;
  afc_pkg::coord_t  max_x;
  afc_pkg::coord_t  max_y;
  afc_pkg::coord_t  max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface afc_res_if;
  logic valid;
  logic ready;
  logic visible;
  logic inverted_box;

  modport source (output valid, visible, inverted_box, input ready);
  modport sink (input valid, visible, inverted_box, output ready);
endinterface

>>> sv/afc_coef.sv
// Matrix registers and the six frustum plane coefficients derived from them.
module afc_coef (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [afc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output afc_pkg::plane_arr_t          planes_o
);

  afc_pkg::cfg_arr_t   cfg_q, cfg_d;
  afc_pkg::plane_arr_t planes_q, planes_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      cfg_d[cfg_idx_i] = cfg_wdata_i;
    end
  end

  // Plane p is base row plus (p even) or minus (p odd) row p/2.
  always_comb begin
    afc_pkg::coef_t m3;
    afc_pkg::coef_t mk;
    afc_pkg::coef_t c;
    planes_d = planes_q;
    for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
      for (int i = 0; i < afc_pkg::NumCols; i++) begin
        m3 = afc_pkg::ext_coef(cfg_d[2*afc_pkg::BaseRow + i/2][32*(i%2) +: 32]);
        mk = afc_pkg::ext_coef(cfg_d[2*(p/2) + i/2][32*(i%2) +: 32]);
        c  = (p % 2 == 0) ? m3 + mk : m3 - mk;
        if (i == afc_pkg::WCol) begin
          planes_d[p].w = c;
        end else begin
          planes_d[p].n[i] = c;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '0;
      planes_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q    <= cfg_d;
      planes_q <= planes_d;
    end
  end

  assign planes_o = planes_q;

endmodule

>>> sv/afc_mult.sv
// Corner selection and per-axis plane products, registered.
module afc_mult (
  input  logic                clk_i,
  input  logic                en_i,
  input  afc_pkg::coord_vec_t lo_i,
  input  afc_pkg::coord_vec_t hi_i,
  input  afc_pkg::plane_arr_t planes_i,
  output afc_pkg::prod_arr_t  prod_o,
  output logic                inv_o
);

  afc_pkg::prod_arr_t prod_d, prod_q;
  logic               inv_d, inv_q;

  always_comb begin
    afc_pkg::coord_t sel;
    inv_d = 1'b0;
    for (int i = 0; i < afc_pkg::NumAxes; i++) begin
      if (lo_i[i] > hi_i[i]) begin
        inv_d = 1'b1;
      end
    end
    // Take the far corner along each normal: max where n >= 0, min otherwise.
    for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
      for (int i = 0; i < afc_pkg::NumAxes; i++) begin
        sel = planes_i[p].n[i][afc_pkg::CoefW-1] ? lo_i[i] : hi_i[i];
        prod_d[p][i] = afc_pkg::prod_t'($signed(planes_i[p].n[i]) * $signed(sel));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      inv_q  <= inv_d;
    end
  end

  assign prod_o = prod_q;
  assign inv_o  = inv_q;

endmodule

>>> sv/afc_reduce.sv
// Per-plane sums of products and offset, sign test and final verdict.
module afc_reduce (
  input  afc_pkg::prod_arr_t  prod_i,
  input  afc_pkg::plane_arr_t planes_i,
  input  logic                inv_i,
  output logic                visible_o
);

  logic [afc_pkg::NumPlanes-1:0] reject;

  always_comb begin
    afc_pkg::sum_t s;
    for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
      s = afc_pkg::sum_t'($signed(planes_i[p].w)) <<< afc_pkg::FracBits;
      for (int i = 0; i < afc_pkg::NumAxes; i++) begin
        s = s + afc_pkg::sum_t'($signed(prod_i[p][i]));
      end
      reject[p] = s[afc_pkg::SumW-1];
    end
  end

  // An inverted box skips the plane test.
  assign visible_o = inv_i | ~(|reject);

endmodule

>>> sv/aabb_frustum_cull_test_unit.sv
// Top level of the axis-aligned box versus view frustum cull unit.
// Takes one box word per clock while no result is stalled and returns one result
// word per box, in order. A box passes through a box register, a product register
// holding the eighteen 33x32 plane products (six planes, three axes, all computed in
// parallel), and the result register. Throughput is one box per cycle; a stalled
// result holds the whole pipeline. The clip matrix is written through cfg_*; the
// plane coefficients update on the same edge as the write, so write only while no
// box is in flight.
module aabb_frustum_cull_test_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [afc_pkg::CfgDataW-1:0] cfg_wdata_i,
  afc_box_if.sink                      box_i,
  afc_res_if.source                    res_o
);

  afc_pkg::plane_arr_t planes;
  afc_pkg::prod_arr_t  prod;
  afc_pkg::coord_vec_t lo_q, hi_q;
  logic                inv;
  logic                visible;
  logic                adv;
  logic                s1_valid_q, s2_valid_q, out_valid_q;
  logic                visible_q, inverted_q;

  // Advance every stage unless a finished word is waiting on the sink.
  assign adv         = !out_valid_q || res_o.ready;
  assign box_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= box_i.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q       <= {box_i.min_z, box_i.min_y, box_i.min_x};
      hi_q       <= {box_i.max_z, box_i.max_y, box_i.max_x};
      visible_q  <= visible;
      inverted_q <= inv;
    end
  end

  afc_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .planes_o    (planes)
  );

  afc_mult u_mult (
    .clk_i    (clk_i),
    .en_i     (adv),
    .lo_i     (lo_q),
    .hi_i     (hi_q),
    .planes_i (planes),
    .prod_o   (prod),
    .inv_o    (inv)
  );

  afc_reduce u_reduce (
    .prod_i    (prod),
    .planes_i  (planes),
    .inv_i     (inv),
    .visible_o (visible)
  );

  assign res_o.valid        = out_valid_q;
  assign res_o.visible      = visible_q;
  assign res_o.inverted_box = inverted_q;

`ifndef SYNTHESIS
  a_inverted_is_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && inverted_q |-> visible_q)
    else $error("inverted box reported as culled");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |=> out_valid_q && $stable(visible_q) && $stable(inverted_q))
    else $error("stalled result word changed or dropped");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_i.valid && box_i.ready |=> s1_valid_q)
    else $error("accepted box word lost at first stage");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s2_valid_q |=> out_valid_q)
    else $error("product stage word not forwarded to result");
`endif

endmodule

>>> tb/aabb_frustum_cull_test_unit_checker.sv
// Cull result checker: tracks the clip matrix, predicts each box word and compares results.
module aabb_frustum_cull_test_unit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [afc_pkg::CfgDataW-1:0] cfg_wdata_i,
  afc_box_if                           box_mon,
  afc_res_if                           res_mon,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  pending_o
);

  typedef struct packed {
    logic visible;
    logic inverted_box;
  } cull_t;

  afc_pkg::coord_t clip_m [afc_pkg::NumCols][afc_pkg::NumCols];
  cull_t           cull_q [$];
  int unsigned     mismatch_cnt;

  // Doubled-quantity plane test: per axis pick max for a non-negative normal, min otherwise.
  function automatic cull_t predict_cull(input afc_pkg::coord_vec_t lo,
                                         input afc_pkg::coord_vec_t hi);
    cull_t               r;
    logic signed [127:0] acc;
    logic signed [127:0] base;
    logic signed [127:0] tilt;
    logic signed [127:0] nrm;
    logic signed [127:0] corner;
    r.visible      = 1'b1;
    r.inverted_box = 1'b0;
    for (int i = 0; i < afc_pkg::NumAxes; i++) begin
      if ($signed(lo[i]) > $signed(hi[i])) r.inverted_box = 1'b1;
    end
    if (!r.inverted_box) begin
      for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
        acc = '0;
        for (int i = 0; i < afc_pkg::NumAxes; i++) begin
          base = clip_m[afc_pkg::BaseRow][i];
          tilt = clip_m[p / 2][i];
          if (p % 2 == 1) tilt = -tilt;
          nrm = base + tilt;
          if (nrm >= 0) begin
            corner = $signed(hi[i]);
          end else begin
            corner = $signed(lo[i]);
          end
          acc = acc + nrm * corner;
        end
        base = clip_m[afc_pkg::BaseRow][afc_pkg::WCol];
        tilt = clip_m[p / 2][afc_pkg::WCol];
        if (p % 2 == 1) tilt = -tilt;
        acc = acc + ((base + tilt) <<< afc_pkg::FracBits);
        if (acc < 0) r.visible = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cull_t               want;
    afc_pkg::coord_vec_t lo;
    afc_pkg::coord_vec_t hi;
    int                  row;
    int                  col;
    if (!rst_ni) begin
      for (int r = 0; r < afc_pkg::NumCols; r++) begin
        for (int c = 0; c < afc_pkg::NumCols; c++) clip_m[r][c] = '0;
      end
      cull_q.delete();
      mismatch_cnt   = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        row = int'(cfg_idx_i) / 2;
        col = (int'(cfg_idx_i) % 2) * 2;
        clip_m[row][col]     = cfg_wdata_i[31:0];
        clip_m[row][col + 1] = cfg_wdata_i[63:32];
      end
      if (res_mon.valid && res_mon.ready) begin
        if (cull_q.size() == 0) begin
          $error("result word with no box pending");
          mismatch_cnt++;
        end else begin
          want = cull_q.pop_front();
          if (res_mon.visible !== want.visible) begin
            $error("visible: expected %0b, actual %0b", want.visible, res_mon.visible);
            mismatch_cnt++;
          end
          if (res_mon.inverted_box !== want.inverted_box) begin
            $error("inverted_box: expected %0b, actual %0b",
                   want.inverted_box, res_mon.inverted_box);
            mismatch_cnt++;
          end
        end
      end
      if (box_mon.valid && box_mon.ready) begin
        lo = {box_mon.min_z, box_mon.min_y, box_mon.min_x};
        hi = {box_mon.max_z, box_mon.max_y, box_mon.max_x};
        cull_q.push_back(predict_cull(lo, hi));
      end
      mismatch_cnt_o <= mismatch_cnt;
      pending_o      <= cull_q.size();
    end
  end

endmodule

>>> tb/aabb_frustum_cull_test_unit_test.sv
// Testbench top for the box versus frustum cull unit: clock, stimulus, stalls and verdict.
module aabb_frustum_cull_test_unit_test;

  localparam logic [31:0] QOne     = 32'h0001_0000;
  localparam logic [31:0] QNegOne  = 32'hFFFF_0000;
  localparam logic [31:0] QNegFifth = 32'hFFFF_CCCD;
  localparam logic [31:0] QZero    = 32'h0000_0000;
  localparam logic [31:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] CoordMin = 32'h8000_0000;

  localparam int unsigned SpanFull    = 0;
  localparam int unsigned SpanNear    = 1;
  localparam int unsigned SpanExtreme = 2;

  localparam int unsigned MatZero     = 0;
  localparam int unsigned MatPersp    = 1;
  localparam int unsigned MatSmall    = 2;
  localparam int unsigned MatFull     = 3;
  localparam int unsigned MatAllMax   = 4;
  localparam int unsigned MatAllMin   = 5;
  localparam int unsigned MatMixedExt = 6;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [afc_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [afc_pkg::CfgDataW-1:0] cfg_wdata;
  int unsigned                  mismatch_cnt;
  int unsigned                  pending;

  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned mode_left;
  logic [1:0]  rx_mode;
  logic        long_hold_go;
  logic        long_hold_taken;

  afc_box_if box_if ();
  afc_res_if res_if ();

  aabb_frustum_cull_test_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .box_i       (box_if),
    .res_o       (res_if)
  );

  aabb_frustum_cull_test_unit_checker cull_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .box_mon        (box_if),
    .res_mon        (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result receiver: random stall modes, plus one long hold to back up the pipeline.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready    <= 1'b0;
      stall_left      <= 0;
      mode_left       <= 0;
      rx_mode         <= 2'd0;
      long_hold_taken <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (long_hold_go && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      stall_left      <= 300;
      res_if.ready    <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= 2'($urandom_range(0, 2));
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        2'd0:    res_if.ready <= 1'b1;
        2'd1:    res_if.ready <= ($urandom_range(0, 3) != 0);
        default: res_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_matrix(input afc_pkg::cfg_arr_t regs);
    cfg_we <= 1'b1;
    for (int r = 0; r < afc_pkg::NumCfg; r++) begin
      cfg_idx   <= afc_pkg::CfgIdxW'(r);
      cfg_wdata <= regs[r];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(input int unsigned kind);
    afc_pkg::cfg_arr_t regs;
    logic [31:0] e0;
    logic [31:0] e1;
    for (int r = 0; r < afc_pkg::NumCfg; r++) begin
      case (kind)
        MatZero:   regs[r] = '0;
        MatAllMax: regs[r] = {CoordMax, CoordMax};
        MatAllMin: regs[r] = {CoordMin, CoordMin};
        MatFull:   regs[r] = {$urandom, $urandom};
        MatSmall: begin
          e0 = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          e1 = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          regs[r] = {e1, e0};
        end
        default: begin
          e0 = $urandom_range(0, 1) ? CoordMax : CoordMin;
          e1 = $urandom_range(0, 1) ? CoordMax : CoordMin;
          regs[r] = {e1, e0};
        end
      endcase
    end
    if (kind == MatPersp) begin
      // unit x and y, z row with near offset, w taken from -z
      regs[0] = {QZero, QOne};
      regs[1] = {QZero, QZero};
      regs[2] = {QOne, QZero};
      regs[3] = {QZero, QZero};
      regs[4] = {QZero, QZero};
      regs[5] = {QNegFifth, QNegOne};
      regs[6] = {QZero, QZero};
      regs[7] = {QZero, QNegOne};
    end
    write_matrix(regs);
  endtask

  // Offer one box word; open a random gap between bursts.
  task automatic send_box(input afc_pkg::coord_vec_t lo, input afc_pkg::coord_vec_t hi);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        box_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    box_if.valid <= 1'b1;
    box_if.min_x <= lo[0];
    box_if.min_y <= lo[1];
    box_if.min_z <= lo[2];
    box_if.max_x <= hi[0];
    box_if.max_y <= hi[1];
    box_if.max_z <= hi[2];
    @(posedge clk_i);
    while (!box_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  function automatic afc_pkg::coord_t pick_coord(input int unsigned span);
    afc_pkg::coord_t v;
    case (span)
      SpanFull: v = $urandom;
      SpanNear: v = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = CoordMin;
          1:       v = CoordMax;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Mostly well-ordered boxes; some forced inverted on one axis, some raw.
  task automatic send_random_box();
    afc_pkg::coord_vec_t lo;
    afc_pkg::coord_vec_t hi;
    afc_pkg::coord_t     a;
    afc_pkg::coord_t     b;
    int unsigned         span;
    int unsigned         shape;
    int unsigned         flip;
    span  = $urandom_range(0, 19);
    span  = (span < 10) ? SpanNear : ((span < 17) ? SpanFull : SpanExtreme);
    shape = $urandom_range(0, 9);
    flip  = $urandom_range(0, afc_pkg::NumAxes - 1);
    for (int i = 0; i < afc_pkg::NumAxes; i++) begin
      a = pick_coord(span);
      b = pick_coord(span);
      if (shape != 9 && $signed(a) > $signed(b)) begin
        lo[i] = b;
        hi[i] = a;
      end else begin
        lo[i] = a;
        hi[i] = b;
      end
      if (shape == 8 && i == flip) begin
        a     = lo[i];
        lo[i] = hi[i];
        hi[i] = a;
      end
    end
    send_box(lo, hi);
  endtask

  // Drop valid and hold until every result word has come back.
  task automatic drain();
    box_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned mat_plan [8];
    mat_plan = '{MatPersp, MatSmall, MatFull, MatAllMax, MatAllMin, MatMixedExt,
                 MatZero, MatSmall};
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    box_if.valid <= 1'b0;
    box_if.min_x <= '0;
    box_if.min_y <= '0;
    box_if.min_z <= '0;
    box_if.max_x <= '0;
    box_if.max_y <= '0;
    box_if.max_z <= '0;
    long_hold_go <= 1'b0;
    burst_left   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero matrix out of reset: everything visible, inverted boxes flagged
    send_box('0, '0);
    send_box({3{CoordMin}}, {3{CoordMax}});
    send_box({QZero, QZero, QOne}, {QZero, QZero, QZero});
    send_box({QZero, QOne, QZero}, {QZero, QZero, QZero});
    send_box({QOne, QZero, QZero}, {QZero, QZero, QZero});
    send_box({3{QOne}}, {3{QOne}});
    drain();

    load_matrix(MatPersp);
    send_box({32'hFFFB_0000, QNegOne, QNegOne}, {32'hFFFC_0000, QOne, QOne});
    send_box({32'h0005_0000, QNegOne, QNegOne}, {32'h000A_0000, QOne, QOne});
    send_box({32'hFFFB_0000, QNegOne, 32'hFF9C_0000}, {32'hFFFC_0000, QOne, 32'hFFA6_0000});
    send_box({3{CoordMin}}, {3{CoordMax}});
    send_box({32'hFFFB_0000, QZero, QZero}, {32'hFFFB_0000, QZero, QZero});
    send_box({32'hFFFB_0000, QOne, QNegOne}, {32'hFFFC_0000, QNegOne, QOne});
    drain();

    load_matrix(MatAllMax);
    send_box({3{CoordMin}}, {3{CoordMax}});
    send_box('0, '0);
    send_box({3{CoordMax}}, {3{CoordMax}});
    send_box({3{CoordMin}}, {3{CoordMin}});
    drain();

    load_matrix(MatAllMin);
    send_box({3{CoordMin}}, {3{CoordMax}});
    send_box('0, '0);
    send_box({3{CoordMax}}, {3{CoordMax}});
    send_box({3{CoordMin}}, {3{CoordMin}});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      load_matrix(mat_plan[ph]);
      for (int n = 0; n < 82; n++) begin
        if (ph == 2 && n == 10) long_hold_go <= 1'b1;
        send_random_box();
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/afc_pkg.sv
sv/afc_ifs.sv
sv/afc_coef.sv
sv/afc_mult.sv
sv/afc_reduce.sv
sv/aabb_frustum_cull_test_unit.sv
tb/aabb_frustum_cull_test_unit_checker.sv
tb/aabb_frustum_cull_test_unit_test.sv
